>>> rtl/core/gse_pkg.sv
`timescale 1ns / 1ps

package gse_pkg;

    // Fixed bytes of the sector image
    localparam logic [7:0] SYNC_BYTE   = 8'hff;
    localparam logic [7:0] GAP_BYTE    = 8'h55;
    localparam logic [7:0] HEADER_MARK = 8'h08;
    localparam logic [7:0] DATA_MARK   = 8'h07;
    localparam logic [7:0] HEADER_PAD  = 8'h0f;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_DISK_ID_FIRST  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DISK_ID_SECOND = 2'd1;

    // Job queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // Output byte counts per job, as last index
    localparam logic [4:0] HEADER_LAST_IDX = 5'd20;
    localparam logic [4:0] GROUP_LAST_IDX  = 5'd4;
    localparam logic [4:0] TAIL_LAST_IDX   = 5'd12;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_GROUP  = 2'd1,
        KIND_TAIL   = 2'd2
    } job_kind_t;

    // One unit of work for the back part. For a header job, b0 holds the
    // header checksum, b1 the sector and b2 the track.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_push_t;

    // 4-to-5 bit group code of one nibble
    function automatic logic [4:0] nibble_code(input logic [3:0] nib);
        logic [4:0] code;
        case (nib)
            4'h0: code = 5'h0a;
            4'h1: code = 5'h0b;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h0e;
            4'h5: code = 5'h0f;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h09;
            4'h9: code = 5'h19;
            4'ha: code = 5'h1a;
            4'hb: code = 5'h1b;
            4'hc: code = 5'h0d;
            4'hd: code = 5'h1d;
            4'he: code = 5'h1e;
            default: code = 5'h15;
        endcase
        return code;
    endfunction

    // Code four bytes, high nibble first, into a 40-bit word
    function automatic logic [39:0] gcr_group(input logic [31:0] four);
        logic [39:0] bits;
        bits = '0;
        for (int i = 0; i < 8; i++)
        begin
            bits[39 - 5*i -: 5] = nibble_code(four[31 - 4*i -: 4]);
        end
        return bits;
    endfunction

endpackage

>>> rtl/core/gse_front.sv
`timescale 1ns / 1ps

module gse_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic [5:0]          track_number,
    input  logic [4:0]          sector_number,
    input  logic [7:0]          disk_id_first,
    input  logic [7:0]          disk_id_second,
    input  logic                q_full,
    output gse_pkg::q_push_t    q_wr
);

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [7:0] pend0_reg;
    logic [7:0] pend0_next;
    logic [7:0] pend1_reg;
    logic [7:0] pend1_next;
    logic [7:0] pend2_reg;
    logic [7:0] pend2_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic       accept;
    logic [1:0] slot;
    logic [7:0] chk;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign slot     = pos_reg[1:0] + 2'd1;
    assign chk      = {3'd0, sector_number} ^ {2'd0, track_number}
                      ^ disk_id_second ^ disk_id_first;

    // Classify the transaction and collect data bytes into groups
    always_comb
    begin
        pos_next   = pos_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        pend2_next = pend2_reg;
        xor_next   = xor_reg;
        q_wr       = '0;
        q_wr.job.kind = gse_pkg::KIND_GROUP;
        if (accept)
        begin
            pos_next = pos_reg + 8'd1;
            if (pos_reg == 8'd0)
            begin
                q_wr.push     = 1'b1;
                q_wr.job.kind = gse_pkg::KIND_HEADER;
                q_wr.job.b0   = chk;
                q_wr.job.b1   = {3'd0, sector_number};
                q_wr.job.b2   = {2'd0, track_number};
                q_wr.job.b3   = gse_pkg::ZERO_BYTE;
                pend0_next    = gse_pkg::DATA_MARK;
                pend1_next    = data_byte;
                xor_next      = data_byte;
            end
            else if (pos_reg == 8'hff)
            begin
                xor_next      = xor_reg ^ data_byte;
                q_wr.push     = 1'b1;
                q_wr.job.kind = gse_pkg::KIND_TAIL;
                q_wr.job.b0   = data_byte;
                q_wr.job.b1   = xor_reg ^ data_byte;
                q_wr.job.b2   = gse_pkg::ZERO_BYTE;
                q_wr.job.b3   = gse_pkg::ZERO_BYTE;
            end
            else
            begin
                xor_next = xor_reg ^ data_byte;
                case (slot)
                    2'd0: pend0_next = data_byte;
                    2'd1: pend1_next = data_byte;
                    2'd2: pend2_next = data_byte;
                    default:
                    begin
                        q_wr.push     = 1'b1;
                        q_wr.job.kind = gse_pkg::KIND_GROUP;
                        q_wr.job.b0   = pend0_reg;
                        q_wr.job.b1   = pend1_reg;
                        q_wr.job.b2   = pend2_reg;
                        q_wr.job.b3   = data_byte;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            pend0_reg <= '0;
            pend1_reg <= '0;
            pend2_reg <= '0;
            xor_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
            xor_reg   <= xor_next;
        end
    end

`ifndef SYNTH
    // A header job leaves only for the first byte of a sector
    a_header_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr.push && q_wr.job.kind == gse_pkg::KIND_HEADER) |-> (pos_reg == 8'd0))
        else $error("header job pushed off sector start");
    // Nothing is pushed without an accepted transaction
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> accept)
        else $error("job pushed without accepted transaction");
    // Position steps by one per accepted transaction
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pos_reg == $past(pos_reg) + 8'd1))
        else $error("byte position did not advance");
`endif

endmodule

>>> rtl/core/gse_queue.sv
`timescale 1ns / 1ps

module gse_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  gse_pkg::q_push_t    q_wr,
    output logic                q_full,
    input  logic                pop,
    output logic                q_valid,
    output gse_pkg::job_t       q_head
);

    gse_pkg::job_t            mem [gse_pkg::QDepth];
    logic [gse_pkg::QAw-1:0]  wr_ptr_reg;
    logic [gse_pkg::QAw-1:0]  rd_ptr_reg;
    logic [gse_pkg::QAw:0]    count_reg;
    logic [gse_pkg::QAw:0]    count_next;
    logic                     do_push;
    logic                     do_pop;

    assign q_full  = (count_reg == (gse_pkg::QAw+1)'(gse_pkg::QDepth));
    assign q_valid = (count_reg != '0);
    assign q_head  = mem[rd_ptr_reg];
    assign do_push = q_wr.push && !q_full;
    assign do_pop  = pop && q_valid;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (gse_pkg::QAw+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (gse_pkg::QAw+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (gse_pkg::QAw)'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (gse_pkg::QAw)'(1);
            end
        end
    end

    // Store the job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.job;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full)
        else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty job queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (gse_pkg::QAw+1)'(gse_pkg::QDepth))
        else $error("job queue count out of range");
`endif

endmodule

>>> rtl/core/gse_back.sv
`timescale 1ns / 1ps

module gse_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          disk_id_first,
    input  logic [7:0]          disk_id_second,
    input  logic                q_valid,
    input  gse_pkg::job_t       q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          gcr_byte,
    output logic                sector_end
);

    gse_pkg::job_t cur_reg;
    logic          cur_valid_reg;
    logic [4:0]    idx_reg;
    logic          out_valid_reg;
    logic [7:0]    byte_reg;
    logic          end_reg;

    logic          advance;
    logic          at_last;
    logic [4:0]    last_idx;
    logic [31:0]   grp_src;
    logic [39:0]   grp_bits;
    logic [2:0]    off;
    logic          use_grp;
    logic [7:0]    byte_val;
    logic          end_val;
    logic [7:0]    grp_byte;

    assign advance = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign at_last = (idx_reg == last_idx);
    assign pop     = q_valid && (!cur_valid_reg || (advance && at_last));

    // Last output index of the current job
    always_comb
    begin
        case (cur_reg.kind)
            gse_pkg::KIND_HEADER: last_idx = gse_pkg::HEADER_LAST_IDX;
            gse_pkg::KIND_TAIL:   last_idx = gse_pkg::TAIL_LAST_IDX;
            default:              last_idx = gse_pkg::GROUP_LAST_IDX;
        endcase
    end

    // Pick the group source or the fixed byte for this output slot
    always_comb
    begin
        grp_src  = {cur_reg.b0, cur_reg.b1, cur_reg.b2, cur_reg.b3};
        off      = idx_reg[2:0];
        use_grp  = 1'b0;
        byte_val = gse_pkg::GAP_BYTE;
        end_val  = 1'b0;
        case (cur_reg.kind)
            gse_pkg::KIND_HEADER:
            begin
                if (idx_reg == 5'd0 || idx_reg == gse_pkg::HEADER_LAST_IDX)
                begin
                    byte_val = gse_pkg::SYNC_BYTE;
                end
                else if (idx_reg <= 5'd5)
                begin
                    use_grp = 1'b1;
                    off     = 3'(idx_reg - 5'd1);
                    grp_src = {gse_pkg::HEADER_MARK, cur_reg.b0, cur_reg.b1,
                               cur_reg.b2};
                end
                else if (idx_reg <= 5'd10)
                begin
                    use_grp = 1'b1;
                    off     = 3'(idx_reg - 5'd6);
                    grp_src = {disk_id_second, disk_id_first,
                               gse_pkg::HEADER_PAD, gse_pkg::HEADER_PAD};
                end
            end
            gse_pkg::KIND_TAIL:
            begin
                if (idx_reg <= 5'd4)
                begin
                    use_grp = 1'b1;
                end
                end_val = (idx_reg == gse_pkg::TAIL_LAST_IDX);
            end
            default:
            begin
                use_grp = 1'b1;
            end
        endcase
    end

    assign grp_bits = gse_pkg::gcr_group(grp_src);

    // Select one of the five coded bytes, MSB first
    always_comb
    begin
        case (off)
            3'd0:    grp_byte = grp_bits[39:32];
            3'd1:    grp_byte = grp_bits[31:24];
            3'd2:    grp_byte = grp_bits[23:16];
            3'd3:    grp_byte = grp_bits[15:8];
            default: grp_byte = grp_bits[7:0];
        endcase
    end

    // Step through the current job and load the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && !at_last)
            begin
                idx_reg <= idx_reg + 5'd1;
            end
            else if (!cur_valid_reg || advance)
            begin
                idx_reg       <= '0;
                cur_valid_reg <= q_valid;
            end
        end
    end

    // Hold payload of the current job and the output byte
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
        end
        if (advance)
        begin
            byte_reg <= use_grp ? grp_byte : byte_val;
            end_reg  <= end_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gcr_byte   = byte_reg;
    assign sector_end = end_reg;

`ifndef SYNTH
    a_end_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sector_end) |-> (gcr_byte == gse_pkg::GAP_BYTE))
        else $error("sector end flagged on non-gap byte");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg <= last_idx))
        else $error("job byte index past job length");
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cur_valid_reg) |-> (advance && at_last))
        else $error("job loaded over unfinished job");
`endif

endmodule

>>> rtl/core/gcr_sector_encoder.sv
`timescale 1ns / 1ps

// GCR sector encoder. Feed the 256 data bytes of a sector in order; track and
// sector numbers are taken with the first byte, and the byte count wraps to a
// new sector after byte 255. Each sector produces a 354-byte image: sync,
// 10-byte coded header, 9-byte gap, sync, 325-byte coded data block and an
// 8-byte gap, with sector_end set on the final gap byte. The output channel
// delivers one byte per clock while it has a job and is not stalled, so the
// sustained rate is set by that byte stream of 354 bytes per 256 input bytes.
// The input side takes one byte per clock until the 4-entry job queue
// between the input classifier and the byte generator fills; it fills during
// the 21-byte header, and since each 4-byte group then becomes 5 output bytes,
// the input is held back by the output through the data block and longer
// during the 13-byte tail. Disk ID registers are
// written through the configuration port, which is always ready; writes to
// indexes other than 0 and 1 are ignored, and writes belong between sectors.

module gcr_sector_encoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic [5:0]                     track_number,
    input  logic [4:0]                     sector_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     gcr_byte,
    output logic                           sector_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gse_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [7:0]                     cfg_data
);

    logic [7:0]         id_first_reg;
    logic [7:0]         id_second_reg;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    gse_pkg::q_push_t   q_wr;
    gse_pkg::job_t      q_head;

    assign cfg_ready = 1'b1;

    // Write disk ID registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_first_reg  <= '0;
            id_second_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gse_pkg::REG_DISK_ID_FIRST:  id_first_reg  <= cfg_data;
                gse_pkg::REG_DISK_ID_SECOND: id_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gse_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .track_number   (track_number),
        .sector_number  (sector_number),
        .disk_id_first  (id_first_reg),
        .disk_id_second (id_second_reg),
        .q_full         (q_full),
        .q_wr           (q_wr)
    );

    gse_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    gse_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .disk_id_first  (id_first_reg),
        .disk_id_second (id_second_reg),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gcr_byte       (gcr_byte),
        .sector_end     (sector_end)
    );

endmodule

>>> dv/tb_gcr_sector_encoder.sv
`timescale 1ns / 1ps

module tb_gcr_sector_encoder;

    // Unused register slots; writes there must leave the disk IDs alone
    localparam logic [gse_pkg::CfgIdxW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [gse_pkg::CfgIdxW-1:0] REG_SPARE_B = 2'd3;

    // 5-bit group codes, nibble 0 in the low bits
    localparam logic [79:0] GCR_CODES = {
        5'h15, 5'h1e, 5'h1d, 5'h0d, 5'h1b, 5'h1a, 5'h19, 5'h09,
        5'h17, 5'h16, 5'h0f, 5'h0e, 5'h13, 5'h12, 5'h0b, 5'h0a
    };

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] track;
        logic [4:0] sector;
    } sector_byte_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } image_byte_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   data_byte = 8'h00;
    logic [5:0]                   track_number = 6'h00;
    logic [4:0]                   sector_number = 5'h00;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [7:0]                   gcr_byte;
    logic                         sector_end;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [gse_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [7:0]                   cfg_data = 8'h00;

    // Encoder image of the block
    logic [7:0]          id_first = 8'h00;
    logic [7:0]          id_second = 8'h00;
    logic [7:0]          sector_pos = 8'h00;
    logic [7:0]          held_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]          data_sum = 8'h00;

    sector_byte_t        pending_bytes [$];
    image_byte_t         image_expected [$];
    int                  queued_items = 0;
    int                  accepted_items = 0;
    int                  results_seen = 0;
    int                  mismatches = 0;

    // Sender and receiver pacing
    logic                in_fire = 1'b0;
    int                  in_gap = 0;
    int                  in_calm = 0;
    int                  in_roll;
    int                  stall_run = 0;
    int                  calm_run = 0;
    int                  hold_cycles = 0;
    logic                hold_done = 1'b0;
    int                  out_roll;
    sector_byte_t        next_byte;

    gcr_sector_encoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .track_number  (track_number),
        .sector_number (sector_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gcr_byte      (gcr_byte),
        .sector_end    (sector_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic push_image(input logic [7:0] value, input logic last);
        image_byte_t b;
        b.value = value;
        b.last = last;
        image_expected.push_back(b);
    endtask

    // Code four bytes into 40 bits and queue them as five bytes, MSB first
    task automatic push_group(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [7:0] d);
        logic [31:0] four;
        logic [39:0] bits;
        four = {a, b, c, d};
        bits = '0;
        for (int i = 0; i < 8; i++)
        begin
            bits = {bits[34:0], GCR_CODES[5 * four[31 - 4*i -: 4] +: 5]};
        end
        for (int i = 4; i >= 0; i--)
        begin
            push_image(bits[8*i +: 8], 1'b0);
        end
    endtask

    // Advance the encoder image by one data byte and queue its output
    task automatic predict_byte(input logic [7:0] data, input logic [5:0] track,
                                input logic [4:0] sector);
        logic [7:0] hdr_sum;
        logic [1:0] slot;
        if (sector_pos == 8'd0)
        begin
            hdr_sum = {3'b000, sector} ^ {2'b00, track} ^ id_second ^ id_first;
            push_image(gse_pkg::SYNC_BYTE, 1'b0);
            push_group(gse_pkg::HEADER_MARK, hdr_sum, {3'b000, sector},
                       {2'b00, track});
            push_group(id_second, id_first, gse_pkg::HEADER_PAD,
                       gse_pkg::HEADER_PAD);
            repeat (9) push_image(gse_pkg::GAP_BYTE, 1'b0);
            push_image(gse_pkg::SYNC_BYTE, 1'b0);
            held_bytes[0] = gse_pkg::DATA_MARK;
            held_bytes[1] = data;
            data_sum = data;
        end
        else if (sector_pos == 8'd255)
        begin
            data_sum = data_sum ^ data;
            push_group(data, data_sum, gse_pkg::ZERO_BYTE, gse_pkg::ZERO_BYTE);
            for (int i = 0; i < 8; i++)
            begin
                push_image(gse_pkg::GAP_BYTE, i == 7);
            end
        end
        else
        begin
            data_sum = data_sum ^ data;
            slot = sector_pos[1:0] + 2'd1;
            if (slot == 2'd3)
            begin
                push_group(held_bytes[0], held_bytes[1], held_bytes[2], data);
            end
            else
            begin
                held_bytes[slot] = data;
            end
        end
        sector_pos = sector_pos + 8'd1;
    endtask

    // Take input transactions into the image, then check output transactions
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            predict_byte(data_byte, track_number, sector_number);
            accepted_items++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (image_expected.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output byte %02h sector_end %0b",
                         $time, gcr_byte, sector_end);
            end
            else if (image_expected[0].value !== gcr_byte
                     || image_expected[0].last !== sector_end)
            begin
                mismatches++;
                $display("%0t: expected byte %02h sector_end %0b, got %02h %0b",
                         $time, image_expected[0].value, image_expected[0].last,
                         gcr_byte, sector_end);
                void'(image_expected.pop_front());
            end
            else
            begin
                void'(image_expected.pop_front());
            end
        end
    end

    // Drive input transactions from the pending queue with random gaps
    always @(negedge clk)
    begin
        if (in_fire || !in_valid)
        begin
            if (in_fire)
            begin
                in_roll = $urandom_range(0, 99);
                if (in_calm > 0)
                begin
                    in_calm--;
                    in_gap = 0;
                end
                else if (in_roll < 4)
                begin
                    in_calm = $urandom_range(20, 80);
                    in_gap = 0;
                end
                else if (in_roll < 55)
                    in_gap = 0;
                else if (in_roll < 92)
                    in_gap = $urandom_range(1, 3);
                else
                    in_gap = $urandom_range(8, 40);
            end
            if (in_gap > 0 || pending_bytes.size() == 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_byte = pending_bytes.pop_front();
                in_valid <= 1'b1;
                data_byte <= next_byte.data;
                track_number <= next_byte.track;
                sector_number <= next_byte.sector;
            end
        end
    end

    // Drive the output stall; hold off once for a long stretch mid-run
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 380)
        begin
            hold_done = 1'b1;
            hold_cycles = 299;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if (calm_run > 0)
        begin
            calm_run--;
            out_stall <= 1'b0;
        end
        else
        begin
            out_roll = $urandom_range(0, 99);
            if (out_roll < 3)
            begin
                calm_run = $urandom_range(30, 120);
                out_stall <= 1'b0;
            end
            else if (out_roll < 65)
                out_stall <= 1'b0;
            else if (out_roll < 95)
            begin
                stall_run = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_run = $urandom_range(10, 50);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [gse_pkg::CfgIdxW-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == gse_pkg::REG_DISK_ID_FIRST)
            id_first = val;
        else if (idx == gse_pkg::REG_DISK_ID_SECOND)
            id_second = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic [5:0] track,
                              input logic [4:0] sector);
        sector_byte_t b;
        b.data = data;
        b.track = track;
        b.sector = sector;
        pending_bytes.push_back(b);
        queued_items++;
    endtask

    // Random data with the odd all-zero or all-one byte
    task automatic queue_random(input int count);
        int roll;
        logic [7:0] data;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                data = 8'h00;
            else if (roll == 1)
                data = 8'hff;
            else
                data = 8'($urandom);
            queue_byte(data, 6'($urandom), 5'($urandom));
        end
    endtask

    // Wait until every byte is taken and the image is out, then let it settle
    task automatic drain_all();
        while (accepted_items != queued_items || image_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed [24];
        directed = '{8'h00, 8'hff, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab,
                     8'hcd, 8'hef, 8'hf0, 8'h0f, 8'haa, 8'h55, 8'h80, 8'h7f,
                     8'hfe, 8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hba, 8'hdc};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First sector: out-of-range track and sector, directed data, then random
        cfg_write(gse_pkg::REG_DISK_ID_FIRST, 8'hff);
        cfg_write(gse_pkg::REG_DISK_ID_SECOND, 8'h00);
        queue_byte(8'h3c, 6'h3f, 5'h1f);
        for (int i = 0; i < 24; i++)
        begin
            if (i % 2 == 0)
                queue_byte(directed[i], 6'h00, 5'h00);
            else
                queue_byte(directed[i], 6'h3f, 5'h1f);
        end
        queue_random(231);
        drain_all();

        // Second sector: swapped extremes, spare register writes are ignored
        cfg_write(gse_pkg::REG_DISK_ID_FIRST, 8'h00);
        cfg_write(gse_pkg::REG_DISK_ID_SECOND, 8'hff);
        cfg_write(REG_SPARE_A, 8'h5a);
        cfg_write(REG_SPARE_B, 8'ha5);
        queue_byte(8'($urandom), 6'd1, 5'd0);
        queue_random(255);
        drain_all();

        // Third sector: random IDs, highest legal track and sector
        cfg_write(gse_pkg::REG_DISK_ID_FIRST, 8'($urandom));
        cfg_write(gse_pkg::REG_DISK_ID_SECOND, 8'($urandom));
        cfg_write(REG_SPARE_B, 8'hff);
        queue_byte(8'($urandom), 6'd35, 5'd20);
        queue_random(20);
        drain_all();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/core/gse_pkg.sv
rtl/core/gse_front.sv
rtl/core/gse_queue.sv
rtl/core/gse_back.sv
rtl/core/gcr_sector_encoder.sv
dv/tb_gcr_sector_encoder.sv
